FILE: src/clt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, codes and constants of the character LCD terminal controller.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_NUM_LINES  = 3'd0;
  localparam logic [2:0] REG_NUM_COLS   = 3'd1;
  localparam logic [2:0] REG_CURSOR_ON  = 3'd2;
  localparam logic [2:0] REG_BLINK_ON   = 3'd3;
  localparam logic [2:0] REG_LARGE_FONT = 3'd4;

  // Input byte classes
  localparam logic [3:0] CLS_OTHER = 4'd0;
  localparam logic [3:0] CLS_ESC   = 4'd1;
  localparam logic [3:0] CLS_NL    = 4'd2;
  localparam logic [3:0] CLS_CR    = 4'd3;
  localparam logic [3:0] CLS_TAB   = 4'd4;
  localparam logic [3:0] CLS_BEL   = 4'd5;
  localparam logic [3:0] CLS_BS    = 4'd6;
  localparam logic [3:0] CLS_FF    = 4'd7;
  localparam logic [3:0] CLS_PRINT = 4'd8;
  localparam logic [3:0] CLS_R     = 4'd9;
  localparam logic [3:0] CLS_H     = 4'd10;

  // Write sequence kinds
  localparam logic [3:0] KIND_NONE   = 4'd0;
  localparam logic [3:0] KIND_ESC    = 4'd1;
  localparam logic [3:0] KIND_INIT   = 4'd2;
  localparam logic [3:0] KIND_HOME   = 4'd3;
  localparam logic [3:0] KIND_CLEAR  = 4'd4;
  localparam logic [3:0] KIND_NL     = 4'd5;
  localparam logic [3:0] KIND_CR     = 4'd6;
  localparam logic [3:0] KIND_BELL   = 4'd7;
  localparam logic [3:0] KIND_BSBELL = 4'd8;
  localparam logic [3:0] KIND_LEFT   = 4'd9;
  localparam logic [3:0] KIND_TAB    = 4'd10;
  localparam logic [3:0] KIND_DATA   = 4'd11;

  // Byte codes
  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_BEL = 8'd7;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_FF  = 8'd12;
  localparam logic [7:0] CH_R   = 8'h52;
  localparam logic [7:0] CH_H   = 8'h48;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TIL = 8'h7E;

  // LCD command words
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_CURSOR_HOME = 8'h02;
  localparam logic [7:0] CMD_ENTRY       = 8'h06;
  localparam logic [7:0] CMD_DISP_OFF    = 8'h08;
  localparam logic [7:0] CMD_LEFT        = 8'h10;
  localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
  localparam logic [7:0] ROW_ODD_OFS     = 8'h40;

  // Pauses in microseconds
  localparam logic [17:0] WAIT_DATA  = 18'd40;
  localparam logic [17:0] WAIT_CMD   = 18'd1000;
  localparam logic [17:0] WAIT_LONG  = 18'd2000;
  localparam logic [17:0] WAIT_FSET  = 18'd10000;
  localparam logic [17:0] WAIT_BELL  = 18'd200000;
  localparam logic [17:0] WAIT_BSEND = 18'd201000;

  localparam logic [2:0] INIT_LAST = 3'd6;
  localparam logic [2:0] BELL_LAST = 3'd3;

  typedef struct packed {
    logic       accept;
    logic [3:0] kind;
    logic       load;
    logic [2:0] step;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       esc_pending;
    logic [3:0] cls;
    logic       col_lt_cols;
    logic       col_nz;
    logic [3:0] tab_cnt;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: src/clt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_dp
// Datapath: configuration, cursor and escape state, write generation and the
// output register.
// ----------------------------------------------------------------------------
module clt_dp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [6:0]      cfg_data_i,
  input  wire logic [7:0]      text_byte_i,
  input  wire clt_pkg::cmd_t   cmd_i,
  output clt_pkg::status_t     status_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output logic                 reg_select_o,
  output logic [7:0]           write_value_o,
  output logic [17:0]          wait_us_o,
  output logic                 last_write_o
);

  logic [2:0]  lines_q;
  logic [6:0]  cols_q;
  logic        cur_q, blink_q, font_q;
  logic        esc_q, esc_d;
  logic [6:0]  col_q, col_d;
  logic [1:0]  row_q, row_d;
  logic [7:0]  byte_q;
  logic        out_valid_q;
  logic        sel_q, last_q;
  logic [7:0]  val_q;
  logic [17:0] wait_q;

  logic [3:0]  cls;
  logic [3:0]  tab_base, tab_cnt;
  logic [7:0]  tab_sum;
  logic [6:0]  tab_room;
  logic [2:0]  nl_last;
  logic [7:0]  addr;
  logic [7:0]  disp_word, fset_word;
  logic        gen_sel;
  logic [7:0]  gen_val;
  logic [17:0] gen_wait;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q <= 3'd2;
      cols_q  <= 7'd20;
      cur_q   <= 1'b0;
      blink_q <= 1'b0;
      font_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        clt_pkg::REG_NUM_LINES:  lines_q <= cfg_data_i[2:0];
        clt_pkg::REG_NUM_COLS:   cols_q  <= cfg_data_i;
        clt_pkg::REG_CURSOR_ON:  cur_q   <= cfg_data_i[0];
        clt_pkg::REG_BLINK_ON:   blink_q <= cfg_data_i[0];
        clt_pkg::REG_LARGE_FONT: font_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (text_byte_i == clt_pkg::CH_ESC) cls = clt_pkg::CLS_ESC;
    else if (text_byte_i == clt_pkg::CH_NL)  cls = clt_pkg::CLS_NL;
    else if (text_byte_i == clt_pkg::CH_CR)  cls = clt_pkg::CLS_CR;
    else if (text_byte_i == clt_pkg::CH_TAB) cls = clt_pkg::CLS_TAB;
    else if (text_byte_i == clt_pkg::CH_BEL) cls = clt_pkg::CLS_BEL;
    else if (text_byte_i == clt_pkg::CH_BS)  cls = clt_pkg::CLS_BS;
    else if (text_byte_i == clt_pkg::CH_FF)  cls = clt_pkg::CLS_FF;
    else if (text_byte_i == clt_pkg::CH_R)   cls = clt_pkg::CLS_R;
    else if (text_byte_i == clt_pkg::CH_H)   cls = clt_pkg::CLS_H;
    else if (text_byte_i >= clt_pkg::CH_SP && text_byte_i <= clt_pkg::CH_TIL)
      cls = clt_pkg::CLS_PRINT;
    else cls = clt_pkg::CLS_OTHER;
  end

  // Spaces up to the next tab stop, capped at the line end
  always_comb begin
    tab_base = 4'd8 - {1'b0, col_q[2:0]};
    tab_sum  = {1'b0, col_q} + {4'b0000, tab_base};
    tab_room = cols_q - col_q;
    tab_cnt  = (tab_sum > {1'b0, cols_q}) ? tab_room[3:0] : tab_base;
  end

  assign status_o.esc_pending = esc_q;
  assign status_o.cls         = cls;
  assign status_o.col_lt_cols = col_q < cols_q;
  assign status_o.col_nz      = col_q != 7'd0;
  assign status_o.tab_cnt     = tab_cnt;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign nl_last = (lines_q != 3'd0) ? lines_q - 3'd1 : 3'd0;

  always_comb begin
    esc_d = esc_q;
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.accept) begin
      esc_d = 1'b0;
      unique case (cmd_i.kind)
        clt_pkg::KIND_ESC: esc_d = 1'b1;
        clt_pkg::KIND_INIT, clt_pkg::KIND_HOME, clt_pkg::KIND_CLEAR: begin
          col_d = 7'd0;
          row_d = 2'd0;
        end
        clt_pkg::KIND_NL: begin
          if ({1'b0, row_q} < nl_last && row_q != 2'd3) begin
            row_d = row_q + 2'd1;
            col_d = 7'd0;
          end else begin
            col_d = cols_q;
          end
        end
        clt_pkg::KIND_CR:   col_d = 7'd0;
        clt_pkg::KIND_LEFT: col_d = col_q - 7'd1;
        clt_pkg::KIND_TAB:  col_d = col_q + {3'b000, tab_cnt};
        clt_pkg::KIND_DATA: col_d = col_q + 7'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      col_q <= 7'd0;
      row_q <= 2'd0;
    end else begin
      esc_q <= esc_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) byte_q <= text_byte_i;
  end

  // Write generation for the current sequence step
  always_comb begin
    addr      = {1'b0, col_q} + (row_q[0] ? clt_pkg::ROW_ODD_OFS : 8'h00)
              + (row_q[1] ? {1'b0, cols_q} : 8'h00);
    disp_word = {4'b0000, 1'b1, 1'b1, cur_q, blink_q};
    fset_word = {2'b00, 1'b1, 1'b0, lines_q != 3'd1, font_q, 2'b00};
    gen_sel   = 1'b0;
    gen_val   = clt_pkg::CMD_CLEAR;
    gen_wait  = clt_pkg::WAIT_LONG;
    unique case (cmd_i.kind)
      clt_pkg::KIND_INIT: begin
        priority if (cmd_i.step < 3'd3) begin
          gen_val  = fset_word;
          gen_wait = clt_pkg::WAIT_FSET;
        end else if (cmd_i.step == 3'd3) begin
          gen_val  = clt_pkg::CMD_DISP_OFF;
          gen_wait = clt_pkg::WAIT_CMD;
        end else if (cmd_i.step == 3'd4) begin
          gen_val  = disp_word;
          gen_wait = clt_pkg::WAIT_CMD;
        end else if (cmd_i.step == 3'd5) begin
          gen_val  = clt_pkg::CMD_ENTRY;
          gen_wait = clt_pkg::WAIT_CMD;
        end else begin
          gen_val  = clt_pkg::CMD_CLEAR;
          gen_wait = clt_pkg::WAIT_LONG;
        end
      end
      clt_pkg::KIND_HOME: gen_val = clt_pkg::CMD_CURSOR_HOME;
      clt_pkg::KIND_NL, clt_pkg::KIND_CR: begin
        gen_val  = clt_pkg::CMD_SET_ADDR | addr;
        gen_wait = clt_pkg::WAIT_CMD;
      end
      clt_pkg::KIND_BELL, clt_pkg::KIND_BSBELL: begin
        gen_val  = cmd_i.step[0] ? disp_word : clt_pkg::CMD_DISP_OFF;
        gen_wait = (cmd_i.kind == clt_pkg::KIND_BSBELL && cmd_i.step == clt_pkg::BELL_LAST)
                 ? clt_pkg::WAIT_BSEND : clt_pkg::WAIT_BELL;
      end
      clt_pkg::KIND_LEFT: begin
        gen_val  = clt_pkg::CMD_LEFT;
        gen_wait = clt_pkg::WAIT_CMD;
      end
      clt_pkg::KIND_TAB: begin
        gen_sel  = 1'b1;
        gen_val  = clt_pkg::CH_SP;
        gen_wait = clt_pkg::WAIT_DATA;
      end
      clt_pkg::KIND_DATA: begin
        gen_sel  = 1'b1;
        gen_val  = byte_q;
        gen_wait = clt_pkg::WAIT_DATA;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sel_q  <= gen_sel;
      val_q  <= gen_val;
      wait_q <= gen_wait;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reg_select_o  = sel_q;
  assign write_value_o = val_q;
  assign wait_us_o     = wait_q;
  assign last_write_o  = last_q;

endmodule
`default_nettype wire

FILE: src/clt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_ctrl
// Controller: decodes each input item into a write sequence and steps it out,
// one write per free slot of the output register.
// ----------------------------------------------------------------------------
module clt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire clt_pkg::status_t  status_i,
  output clt_pkg::cmd_t          cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic       state_q, state_d;
  logic [3:0] kind_q, kind_d;
  logic [2:0] step_q, step_d;
  logic [2:0] lastidx_q, lastidx_d;
  logic [3:0] dec_kind;
  logic [3:0] dec_cnt;
  logic       accept;

  // Byte class and cursor state give the sequence and its write count
  always_comb begin
    dec_kind = clt_pkg::KIND_NONE;
    if (status_i.esc_pending) begin
      if (status_i.cls == clt_pkg::CLS_R)      dec_kind = clt_pkg::KIND_INIT;
      else if (status_i.cls == clt_pkg::CLS_H) dec_kind = clt_pkg::KIND_HOME;
    end else begin
      unique case (status_i.cls)
        clt_pkg::CLS_ESC: dec_kind = clt_pkg::KIND_ESC;
        clt_pkg::CLS_NL:  dec_kind = clt_pkg::KIND_NL;
        clt_pkg::CLS_CR:  dec_kind = clt_pkg::KIND_CR;
        clt_pkg::CLS_TAB:
          if (status_i.col_lt_cols) dec_kind = clt_pkg::KIND_TAB;
        clt_pkg::CLS_BEL: dec_kind = clt_pkg::KIND_BELL;
        clt_pkg::CLS_BS:
          dec_kind = status_i.col_nz ? clt_pkg::KIND_LEFT : clt_pkg::KIND_BSBELL;
        clt_pkg::CLS_FF:  dec_kind = clt_pkg::KIND_CLEAR;
        clt_pkg::CLS_PRINT, clt_pkg::CLS_R, clt_pkg::CLS_H:
          if (status_i.col_lt_cols) dec_kind = clt_pkg::KIND_DATA;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (dec_kind)
      clt_pkg::KIND_INIT:  dec_cnt = {1'b0, clt_pkg::INIT_LAST} + 4'd1;
      clt_pkg::KIND_BELL, clt_pkg::KIND_BSBELL:
        dec_cnt = {1'b0, clt_pkg::BELL_LAST} + 4'd1;
      clt_pkg::KIND_TAB:   dec_cnt = status_i.tab_cnt;
      clt_pkg::KIND_HOME, clt_pkg::KIND_CLEAR, clt_pkg::KIND_NL, clt_pkg::KIND_CR,
      clt_pkg::KIND_LEFT, clt_pkg::KIND_DATA: dec_cnt = 4'd1;
      default:             dec_cnt = 4'd0;
    endcase
  end

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    step_d    = step_q;
    lastidx_d = lastidx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && dec_cnt != 4'd0) begin
          state_d   = ST_EMIT;
          kind_d    = dec_kind;
          step_d    = 3'd0;
          lastidx_d = 3'(dec_cnt - 4'd1);
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          step_d = step_q + 3'd1;
          if (step_q == lastidx_q) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kind_q    <= clt_pkg::KIND_NONE;
      step_q    <= 3'd0;
      lastidx_q <= 3'd0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      step_q    <= step_d;
      lastidx_q <= lastidx_d;
    end
  end

  always_comb begin
    cmd_o.accept = accept;
    cmd_o.kind   = accept ? dec_kind : kind_q;
    cmd_o.load   = (state_q == ST_EMIT) && status_i.out_free;
    cmd_o.step   = step_q;
    cmd_o.last   = step_q == lastidx_q;
  end

endmodule
`default_nettype wire

FILE: src/char_lcd_terminal_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_terminal_controller
// Text byte stream to character LCD register writes, with cursor tracking.
// ----------------------------------------------------------------------------
// Each accepted text byte is decoded combinationally and then produces its LCD
// writes one per cycle, while the output register is free, from a sequencer
// into a single output register; the input is not ready again until the
// byte's last write is loaded (n writes, n is 0 to 8: eight for a full tab,
// seven for the init sequence, four for the bell), and a byte with no writes
// leaves the input ready. The last write of a byte carries last_write.
// Configuration writes are taken every cycle; change them only while idle.
// ----------------------------------------------------------------------------
module char_lcd_terminal_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  text_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             reg_select_o,
  output logic [7:0]       write_value_o,
  output logic [17:0]      wait_us_o,
  output logic             last_write_o
);

  clt_pkg::cmd_t    cmd;
  clt_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  clt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  clt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .text_byte_i   (text_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .reg_select_o  (reg_select_o),
    .write_value_o (write_value_o),
    .wait_us_o     (wait_us_o),
    .last_write_o  (last_write_o)
  );

  // Writes are loaded only while a sequence runs
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !in_ready_o)
    else $error("write loaded while input ready");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  // Loading the final write frees the input next cycle
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && cmd.last |=> in_ready_o && out_valid_o && last_write_o)
    else $error("sequence did not end after final write");

endmodule
`default_nettype wire
